// File: rtl/multi_axis_dda_step_generator_top_macros.svh
// Assertion macros for the DDA step generator.
// Included by the top level; needs clk and rst in scope at the point of use.
`ifndef MULTI_AXIS_DDA_STEP_GENERATOR_TOP_MACROS_SVH
`define MULTI_AXIS_DDA_STEP_GENERATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define MDDA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define MDDA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MDDA_ASSERT_NOW(name, ante, cons, msg)
`define MDDA_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// File: rtl/mdda_pkg.sv
// Package for the DDA step generator: sizes, codes and shared types.
// No dependencies; used by every other source file but the macros header.
`timescale 1ns / 1ps

package mdda_pkg;

  localparam int JOINTS  = 4;
  localparam int JOINT_W = 2;
  localparam int ADDR_W  = 5;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_ARM   = 3'd2;
  localparam logic [2:0] OP_RAMP  = 3'd3;
  localparam logic [2:0] OP_SETPOS = 3'd4;

  localparam logic [1:0] PH_NONE   = 2'd0;
  localparam logic [1:0] PH_ACCEL  = 2'd1;
  localparam logic [1:0] PH_CRUISE = 2'd2;
  localparam logic [1:0] PH_DECEL  = 2'd3;

  localparam logic [2:0] REG_MASTER_COUNT = 3'd0;
  localparam logic [2:0] REG_TRACK_STEPS  = 3'd1;
  localparam logic [2:0] REG_RAMP_ENABLE  = 3'd2;
  localparam logic [2:0] REG_RAMP_START   = 3'd3;
  localparam logic [2:0] REG_RAMP_CRUISE  = 3'd4;
  localparam logic [2:0] REG_RAMP_STEP    = 3'd5;
  localparam logic [2:0] REG_RAMP_DECEL   = 3'd6;
  localparam logic [2:0] REG_RAMP_TOTAL   = 3'd7;

  typedef struct packed {
    logic [30:0] master_count;
    logic        track_steps;
    logic        ramp_enable;
    logic [15:0] start_period;
    logic [15:0] cruise_period;
    logic [15:0] period_step;
    logic [15:0] decel_point;
    logic [30:0] ramp_total_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [JOINT_W-1:0] joint;
    logic signed [31:0] joint_delta;
    logic signed [31:0] position_value;
    logic [JOINTS-1:0]  pos_ok_mask;
    logic [JOINTS-1:0]  neg_ok_mask;
  } cmd_t;

  typedef struct packed {
    logic [JOINTS-1:0]  step_out;
    logic [JOINTS-1:0]  dir_mask;
    logic               limit_abort;
    logic               move_done;
    logic [JOINTS-1:0]  active_axes;
    logic signed [31:0] joint_position;
    logic               tick_live;
  } axes_res_t;

  typedef struct packed {
    logic [15:0] timer_compare;
    logic [1:0]  ramp_state;
  } ramp_res_t;

  typedef struct packed {
    logic [JOINTS-1:0]  step_out;
    logic [JOINTS-1:0]  dir_mask;
    logic               limit_abort;
    logic               move_done;
    logic [15:0]        timer_compare;
    logic [JOINTS-1:0]  active_axes;
    logic signed [31:0] joint_position;
    logic [1:0]         ramp_state;
  } res_t;

endpackage

// File: rtl/mdda_if.sv
// Handshake channel interfaces for the DDA step generator: command in, result out.
// Depends on mdda_pkg.
`timescale 1ns / 1ps

interface mdda_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     op;
  logic [mdda_pkg::JOINT_W-1:0]   joint;
  logic signed [31:0]             joint_delta;
  logic signed [31:0]             position_value;
  logic [mdda_pkg::JOINTS-1:0]    pos_ok_mask;
  logic [mdda_pkg::JOINTS-1:0]    neg_ok_mask;

  modport source (
    output valid, op, joint, joint_delta, position_value, pos_ok_mask, neg_ok_mask,
    input  ready
  );
  modport sink (
    input  valid, op, joint, joint_delta, position_value, pos_ok_mask, neg_ok_mask,
    output ready
  );
endinterface

interface mdda_res_if;
  logic                           valid;
  logic                           ready;
  logic [mdda_pkg::JOINTS-1:0]    step_out;
  logic [mdda_pkg::JOINTS-1:0]    dir_mask;
  logic                           limit_abort;
  logic                           move_done;
  logic [15:0]                    timer_compare;
  logic [mdda_pkg::JOINTS-1:0]    active_axes;
  logic signed [31:0]             joint_position;
  logic [1:0]                     ramp_state;

  modport source (
    output valid, step_out, dir_mask, limit_abort, move_done, timer_compare,
           active_axes, joint_position, ramp_state,
    input  ready
  );
  modport sink (
    input  valid, step_out, dir_mask, limit_abort, move_done, timer_compare,
           active_axes, joint_position, ramp_state,
    output ready
  );
endinterface

// File: rtl/mdda_cfg.sv
// APB-style configuration registers for the DDA step generator.
// Depends on mdda_pkg.
`timescale 1ns / 1ps

module mdda_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mdda_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output mdda_pkg::cfg_t              cfg
);

  mdda_pkg::cfg_t regs;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.master_count      <= 31'd1;
      regs.track_steps       <= 1'b0;
      regs.ramp_enable       <= 1'b0;
      regs.start_period      <= 16'hFFFF;
      regs.cruise_period     <= 16'd1;
      regs.period_step       <= 16'd1;
      regs.decel_point       <= 16'd0;
      regs.ramp_total_ticks  <= 31'd0;
    end else if (wr_en) begin
      case (reg_idx)
        mdda_pkg::REG_MASTER_COUNT: regs.master_count      <= pwdata[30:0];
        mdda_pkg::REG_TRACK_STEPS:  regs.track_steps       <= pwdata[0];
        mdda_pkg::REG_RAMP_ENABLE:  regs.ramp_enable       <= pwdata[0];
        mdda_pkg::REG_RAMP_START:   regs.start_period      <= pwdata[15:0];
        mdda_pkg::REG_RAMP_CRUISE:  regs.cruise_period     <= pwdata[15:0];
        mdda_pkg::REG_RAMP_STEP:    regs.period_step       <= pwdata[15:0];
        mdda_pkg::REG_RAMP_DECEL:   regs.decel_point       <= pwdata[15:0];
        mdda_pkg::REG_RAMP_TOTAL:   regs.ramp_total_ticks  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mdda_pkg::REG_MASTER_COUNT: prdata = {1'b0, regs.master_count};
      mdda_pkg::REG_TRACK_STEPS:  prdata = {31'd0, regs.track_steps};
      mdda_pkg::REG_RAMP_ENABLE:  prdata = {31'd0, regs.ramp_enable};
      mdda_pkg::REG_RAMP_START:   prdata = {16'd0, regs.start_period};
      mdda_pkg::REG_RAMP_CRUISE:  prdata = {16'd0, regs.cruise_period};
      mdda_pkg::REG_RAMP_STEP:    prdata = {16'd0, regs.period_step};
      mdda_pkg::REG_RAMP_DECEL:   prdata = {16'd0, regs.decel_point};
      mdda_pkg::REG_RAMP_TOTAL:   prdata = {1'b0, regs.ramp_total_ticks};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/mdda_ramp.sv
// Trapezoidal period ramp: phase, current period and ticks left.
// Depends on mdda_pkg; driven by the top level.
`timescale 1ns / 1ps

module mdda_ramp (
  input  logic                 clk,
  input  logic                 rst,
  input  mdda_pkg::cfg_t       cfg,
  input  logic                 load,
  input  logic                 start,
  input  logic                 advance,
  output mdda_pkg::ramp_res_t  res
);

  logic [1:0]  phase, phase_next;
  logic [15:0] period, period_next;
  logic [30:0] ticks_left, ticks_left_next;

  always_comb begin
    logic [1:0]  ph;
    logic [15:0] cp;
    phase_next      = phase;
    period_next     = period;
    ticks_left_next = ticks_left;
    ph = phase;
    cp = period;
    if (start) begin
      if (!cfg.ramp_enable || cfg.cruise_period >= cfg.start_period ||
          cfg.ramp_total_ticks < 31'd4 || cfg.decel_point == 16'd0) begin
        phase_next = mdda_pkg::PH_NONE;
      end else begin
        phase_next      = mdda_pkg::PH_ACCEL;
        period_next     = cfg.start_period;
        ticks_left_next = cfg.ramp_total_ticks;
      end
    end else if (advance && phase != mdda_pkg::PH_NONE) begin
      if (ph == mdda_pkg::PH_ACCEL) begin
        if ({1'b0, cp} > {1'b0, cfg.cruise_period} + {1'b0, cfg.period_step}) begin
          cp = cp - cfg.period_step;
        end else begin
          cp = cfg.cruise_period;
          ph = mdda_pkg::PH_CRUISE;
        end
      end
      if (ph != mdda_pkg::PH_DECEL && ticks_left <= {15'd0, cfg.decel_point}) begin
        ph = mdda_pkg::PH_DECEL;
      end
      if (ph == mdda_pkg::PH_DECEL) begin
        if ({1'b0, cp} + {1'b0, cfg.period_step} < {1'b0, cfg.start_period}) begin
          cp = cp + cfg.period_step;
        end else begin
          cp = cfg.start_period;
        end
      end
      phase_next  = ph;
      period_next = cp;
      if (ticks_left != 31'd0) begin
        ticks_left_next = ticks_left - 31'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= mdda_pkg::PH_NONE;
      period     <= 16'd0;
      ticks_left <= 31'd0;
    end else if (load) begin
      phase      <= phase_next;
      period     <= period_next;
      ticks_left <= ticks_left_next;
    end
  end

  assign res.timer_compare = (period_next == 16'd0) ? 16'd0 : period_next - 16'd1;
  assign res.ramp_state    = phase_next;

endmodule

// File: rtl/mdda_axes.sv
// Per-joint DDA accumulators, directions, step counts and positions.
// Depends on mdda_pkg; driven by the top level.
`timescale 1ns / 1ps

module mdda_axes (
  input  logic                 clk,
  input  logic                 rst,
  input  mdda_pkg::cfg_t       cfg,
  input  logic                 load,
  input  mdda_pkg::cmd_t       cmd,
  output mdda_pkg::axes_res_t  res
);

  localparam int J = mdda_pkg::JOINTS;

  logic [31:0]        acc  [J];
  logic [30:0]        mag  [J];
  logic [30:0]        rem  [J];
  logic signed [31:0] pos  [J];
  logic [J-1:0]       dir;
  logic [J-1:0]       axis_mask;

  logic [31:0]        acc_next [J];
  logic [30:0]        mag_next [J];
  logic [30:0]        rem_next [J];
  logic signed [31:0] pos_next [J];
  logic [J-1:0]       dir_next;
  logic [J-1:0]       axis_mask_next;

  logic [31:0]  sum [J];
  logic [J-1:0] fire;
  logic [J-1:0] dir_ok;
  logic [J-1:0] stepped;
  logic         blocked;
  logic         abort;
  logic         done;
  logic         jvalid;
  logic [31:0]  neg_delta;
  logic [30:0]  arm_mag;

  assign jvalid    = ({1'b0, cmd.joint} < 3'(J));
  assign neg_delta = 32'd0 - cmd.joint_delta;
  assign arm_mag   = cmd.joint_delta[31] ? (neg_delta[31] ? 31'h7FFF_FFFF : neg_delta[30:0])
                                         : cmd.joint_delta[30:0];

  always_comb begin
    for (int i = 0; i < J; i++) begin
      sum[i]    = acc[i] + {1'b0, mag[i]};
      fire[i]   = axis_mask[i] && (mag[i] != 31'd0) && (sum[i] >= {1'b0, cfg.master_count});
      dir_ok[i] = dir[i] ? cmd.pos_ok_mask[i] : cmd.neg_ok_mask[i];
    end
  end

  always_comb begin
    acc_next       = acc;
    mag_next       = mag;
    rem_next       = rem;
    pos_next       = pos;
    dir_next       = dir;
    axis_mask_next = axis_mask;
    stepped        = '0;
    blocked        = 1'b0;
    abort          = 1'b0;
    done           = 1'b0;
    case (cmd.op)
      mdda_pkg::OP_TICK: begin
        if (axis_mask != '0) begin
          for (int i = 0; i < J; i++) begin
            if (axis_mask[i] && mag[i] != 31'd0) begin
              acc_next[i] = fire[i] ? sum[i] - {1'b0, cfg.master_count} : sum[i];
            end
          end
          // lowest joint first; a forbidden step stops the rest
          for (int i = 0; i < J; i++) begin
            if (fire[i] && !blocked) begin
              if (!dir_ok[i]) begin
                blocked = 1'b1;
              end else begin
                stepped[i]  = 1'b1;
                pos_next[i] = dir[i] ? pos[i] + 32'sd1 : pos[i] - 32'sd1;
                if (cfg.track_steps && rem[i] != 31'd0) begin
                  rem_next[i] = rem[i] - 31'd1;
                  if (rem[i] == 31'd1) begin
                    axis_mask_next[i] = 1'b0;
                    mag_next[i]       = 31'd0;
                  end
                end
              end
            end
          end
          if (blocked) begin
            for (int i = 0; i < J; i++) begin
              mag_next[i] = 31'd0;
            end
            axis_mask_next = '0;
            abort          = 1'b1;
            done           = cfg.track_steps;
          end else if (fire != '0) begin
            done = cfg.track_steps && (axis_mask_next == '0);
          end
        end
      end
      mdda_pkg::OP_CLEAR: begin
        axis_mask_next = '0;
        for (int i = 0; i < J; i++) begin
          mag_next[i] = 31'd0;
          acc_next[i] = 32'd0;
          rem_next[i] = 31'd0;
        end
      end
      mdda_pkg::OP_ARM: begin
        if (jvalid && cmd.joint_delta != 32'sd0) begin
          dir_next[cmd.joint]       = !cmd.joint_delta[31];
          mag_next[cmd.joint]       = arm_mag;
          acc_next[cmd.joint]       = 32'd0;
          rem_next[cmd.joint]       = cfg.track_steps ? arm_mag : 31'd0;
          axis_mask_next[cmd.joint] = 1'b1;
        end
      end
      mdda_pkg::OP_SETPOS: begin
        if (jvalid) begin
          pos_next[cmd.joint] = cmd.position_value;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < J; i++) begin
        acc[i] <= 32'd0;
        mag[i] <= 31'd0;
        rem[i] <= 31'd0;
        pos[i] <= 32'sd0;
      end
      dir       <= '0;
      axis_mask <= '0;
    end else if (load) begin
      acc       <= acc_next;
      mag       <= mag_next;
      rem       <= rem_next;
      pos       <= pos_next;
      dir       <= dir_next;
      axis_mask <= axis_mask_next;
    end
  end

  assign res.step_out       = stepped;
  assign res.dir_mask       = dir_next;
  assign res.limit_abort    = abort;
  assign res.move_done      = done;
  assign res.active_axes    = axis_mask_next;
  assign res.joint_position = jvalid ? pos_next[cmd.joint] : 32'sd0;
  assign res.tick_live      = (cmd.op == mdda_pkg::OP_TICK) && (axis_mask != '0);

endmodule

// File: rtl/multi_axis_dda_step_generator_top.sv
// Top level of the four-joint DDA step generator with trapezoidal ramp.
// Depends on mdda_pkg, mdda_if, mdda_cfg, mdda_ramp, mdda_axes and the macros header.
//
//   channel | kind            | transfer when
//   cmd     | command in      | cmd.valid && cmd.ready
//   res     | result out      | res.valid && res.ready
//   apb     | register writes | psel && penable && pwrite (pready tied high)
//
// A command passes through the command register, then the result register.
// One command per cycle sustained while res.ready stays high; state and result register load in the same cycle.
// cmd.ready drops only while both registers are full and res.ready is low.
// Synchronous active-high reset clears joint, ramp and handshake state; no clearing pass.
`timescale 1ns / 1ps
`include "multi_axis_dda_step_generator_top_macros.svh"

module multi_axis_dda_step_generator_top (
  input  logic                        clk,
  input  logic                        rst,
  mdda_cmd_if.sink                    cmd,
  mdda_res_if.source                  res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mdda_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  mdda_pkg::cfg_t      cfg;
  mdda_pkg::cmd_t      cmd_item;
  mdda_pkg::res_t      res_item;
  mdda_pkg::axes_res_t axes_res;
  mdda_pkg::ramp_res_t ramp_res;
  logic                cmd_full;
  logic                res_full;
  logic                exec;

  assign exec      = cmd_full && (!res_full || res.ready);
  assign cmd.ready = !cmd_full || exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_full <= 1'b0;
    end else if (cmd.ready) begin
      cmd_full <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_item.op             <= cmd.op;
      cmd_item.joint          <= cmd.joint;
      cmd_item.joint_delta    <= cmd.joint_delta;
      cmd_item.position_value <= cmd.position_value;
      cmd_item.pos_ok_mask    <= cmd.pos_ok_mask;
      cmd_item.neg_ok_mask    <= cmd.neg_ok_mask;
    end
  end

  mdda_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mdda_axes u_axes (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .load (exec),
    .cmd  (cmd_item),
    .res  (axes_res)
  );

  mdda_ramp u_ramp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .load    (exec),
    .start   (cmd_item.op == mdda_pkg::OP_RAMP),
    .advance (axes_res.tick_live),
    .res     (ramp_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (exec) begin
      res_full <= 1'b1;
    end else if (res.ready) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res_item.step_out       <= axes_res.step_out;
      res_item.dir_mask       <= axes_res.dir_mask;
      res_item.limit_abort    <= axes_res.limit_abort;
      res_item.move_done      <= axes_res.move_done;
      res_item.timer_compare  <= ramp_res.timer_compare;
      res_item.active_axes    <= axes_res.active_axes;
      res_item.joint_position <= axes_res.joint_position;
      res_item.ramp_state     <= ramp_res.ramp_state;
    end
  end

  assign res.valid          = res_full;
  assign res.step_out       = res_item.step_out;
  assign res.dir_mask       = res_item.dir_mask;
  assign res.limit_abort    = res_item.limit_abort;
  assign res.move_done      = res_item.move_done;
  assign res.timer_compare  = res_item.timer_compare;
  assign res.active_axes    = res_item.active_axes;
  assign res.joint_position = res_item.joint_position;
  assign res.ramp_state     = res_item.ramp_state;

  `MDDA_ASSERT_NOW(a_abort_clears_axes, res_full && res_item.limit_abort, res_item.active_axes == '0, "limit abort left joints active")
  `MDDA_ASSERT_NOW(a_done_means_idle, res_full && res_item.move_done, res_item.active_axes == '0, "move done with joints still active")
  `MDDA_ASSERT_NEXT(a_no_step_off_tick, exec && cmd_item.op != mdda_pkg::OP_TICK, res_item.step_out == '0 && !res_item.limit_abort, "step or abort on a non-tick command")
  `MDDA_ASSERT_NOW(a_stall_only_when_full, !cmd.ready, cmd_full && res_full && !res.ready, "command stalled without back-pressure")

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for the four-joint DDA step generator with trapezoid ramp.
// Uses mdda_pkg and the mdda_cmd_if / mdda_res_if channels; drives the APB port
// and checks every result transfer against an in-bench copy of the joint state.
`timescale 1ns / 1ps

module tb_top;
  import mdda_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          HOLD_CYCLES = 120;
  localparam int          BATCH_ITEMS = 34;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;

  mdda_cmd_if cmd_ch();
  mdda_res_if res_ch();

  multi_axis_dda_step_generator_top dut (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .res(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // register copy and joint/ramp state
  cfg_t        regs;
  logic [31:0] joint_acc  [JOINTS];
  logic [30:0] joint_mag  [JOINTS];
  logic        joint_dir  [JOINTS];
  logic [31:0] joint_left [JOINTS];
  logic [31:0] joint_pos  [JOINTS];
  logic [3:0]  live_axes;
  logic [1:0]  prof_phase;
  logic [31:0] ramp_period;
  logic [31:0] ramp_left;

  cmd_t        cmd_backlog[$];
  res_t        step_results_q[$];
  cmd_t        on_wire;
  res_t        want_now;

  int          tx_idle = 0;
  int          rx_idle = 0;
  int          errors = 0;
  int          hold_left = 0;
  logic        hold_req = 1'b0;
  int unsigned cycle_count = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("tb: mismatch on %s: got %h, want %h", what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report(what, got, want);
  endtask

  function automatic res_t run_command(cmd_t c);
    res_t        r;
    logic [3:0]  fire;
    logic [31:0] mag;
    logic        ok;
    logic        halted;
    r = '0;
    fire = '0;
    halted = 1'b0;
    case (c.op)
      OP_TICK: begin
        if (live_axes != 0) begin
          if (prof_phase != PH_NONE) begin
            if (prof_phase == PH_ACCEL) begin
              if (ramp_period > regs.cruise_period + regs.period_step) begin
                ramp_period = ramp_period - regs.period_step;
              end else begin
                ramp_period = regs.cruise_period;
                prof_phase = PH_CRUISE;
              end
            end
            if (prof_phase != PH_DECEL && ramp_left <= regs.decel_point)
              prof_phase = PH_DECEL;
            if (prof_phase == PH_DECEL) begin
              if (ramp_period + regs.period_step < regs.start_period)
                ramp_period = ramp_period + regs.period_step;
              else
                ramp_period = regs.start_period;
            end
            ramp_period = ramp_period & 32'h0000_FFFF;
            if (ramp_left > 0)
              ramp_left = ramp_left - 1;
          end
          for (int i = 0; i < JOINTS; i++) begin
            if (live_axes[i] && joint_mag[i] != 0) begin
              joint_acc[i] = joint_acc[i] + joint_mag[i];
              if (joint_acc[i] >= regs.master_count) begin
                joint_acc[i] = joint_acc[i] - regs.master_count;
                fire[i] = 1'b1;
              end
            end
          end
          for (int i = 0; i < JOINTS; i++) begin
            if (fire[i] && !halted) begin
              ok = joint_dir[i] ? c.pos_ok_mask[i] : c.neg_ok_mask[i];
              if (!ok) begin
                // soft limit: whole move dropped, earlier steps stand
                for (int j = 0; j < JOINTS; j++)
                  joint_mag[j] = '0;
                live_axes = '0;
                r.limit_abort = 1'b1;
                r.move_done = regs.track_steps;
                halted = 1'b1;
              end else begin
                r.step_out[i] = 1'b1;
                joint_pos[i] = joint_dir[i] ? joint_pos[i] + 1 : joint_pos[i] - 1;
                if (regs.track_steps && joint_left[i] > 0) begin
                  joint_left[i] = joint_left[i] - 1;
                  if (joint_left[i] == 0) begin
                    live_axes[i] = 1'b0;
                    joint_mag[i] = '0;
                  end
                end
              end
            end
          end
          if (fire != 0 && !halted && regs.track_steps && live_axes == 0)
            r.move_done = 1'b1;
        end
      end
      OP_CLEAR: begin
        live_axes = '0;
        for (int i = 0; i < JOINTS; i++) begin
          joint_mag[i] = '0;
          joint_acc[i] = '0;
          joint_left[i] = '0;
        end
      end
      OP_ARM: begin
        if (c.joint_delta != 0) begin
          mag = c.joint_delta[31] ? 32'd0 - c.joint_delta : c.joint_delta;
          if (mag > 32'h7FFF_FFFF)
            mag = 32'h7FFF_FFFF;
          joint_dir[c.joint] = ~c.joint_delta[31];
          joint_mag[c.joint] = mag[30:0];
          joint_acc[c.joint] = '0;
          joint_left[c.joint] = regs.track_steps ? mag : 32'd0;
          live_axes[c.joint] = 1'b1;
        end
      end
      OP_RAMP: begin
        if (!regs.ramp_enable || regs.cruise_period >= regs.start_period ||
            regs.ramp_total_ticks < 4 || regs.decel_point == 0) begin
          prof_phase = PH_NONE;
        end else begin
          ramp_period = regs.start_period;
          ramp_left = regs.ramp_total_ticks;
          prof_phase = PH_ACCEL;
        end
      end
      OP_SETPOS: begin
        joint_pos[c.joint] = c.position_value;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < JOINTS; i++)
      r.dir_mask[i] = joint_dir[i];
    r.timer_compare = (ramp_period != 0) ? 16'(ramp_period - 1) : 16'd0;
    r.active_axes = live_axes;
    r.joint_position = joint_pos[c.joint];
    r.ramp_state = prof_phase;
    return r;
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready)
        step_results_q.push_back(run_command(on_wire));
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= tx_idle) begin
          on_wire              <= cmd_backlog[0];
          cmd_ch.op             <= cmd_backlog[0].op;
          cmd_ch.joint          <= cmd_backlog[0].joint;
          cmd_ch.joint_delta    <= cmd_backlog[0].joint_delta;
          cmd_ch.position_value <= cmd_backlog[0].position_value;
          cmd_ch.pos_ok_mask    <= cmd_backlog[0].pos_ok_mask;
          cmd_ch.neg_ok_mask    <= cmd_backlog[0].neg_ok_mask;
          cmd_ch.valid          <= 1'b1;
          void'(cmd_backlog.pop_front());
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (step_results_q.size() == 0) begin
          report("unexpected result transfer", '0, '0);
        end else begin
          want_now = step_results_q.pop_front();
          check_field("step_out", res_ch.step_out, want_now.step_out);
          check_field("dir_mask", res_ch.dir_mask, want_now.dir_mask);
          check_field("limit_abort", res_ch.limit_abort, want_now.limit_abort);
          check_field("move_done", res_ch.move_done, want_now.move_done);
          check_field("timer_compare", res_ch.timer_compare, want_now.timer_compare);
          check_field("active_axes", res_ch.active_axes, want_now.active_axes);
          check_field("joint_position", res_ch.joint_position, want_now.joint_position);
          check_field("ramp_state", res_ch.ramp_state, want_now.ramp_state);
        end
      end
      res_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst)
      hold_left <= 0;
    else if (hold_req)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic cmd_t make_cmd(logic [2:0] op, logic [1:0] jt, logic [31:0] delta,
                                    logic [31:0] pval, logic [3:0] pm, logic [3:0] nm);
    cmd_t c;
    c.op = op;
    c.joint = jt;
    c.joint_delta = delta;
    c.position_value = pval;
    c.pos_ok_mask = pm;
    c.neg_ok_mask = nm;
    return c;
  endfunction

  task automatic push_cmd(input cmd_t c, ref int n);
    cmd_backlog.push_back(c);
    if (c.op <= OP_SETPOS)
      n++;
  endtask

  function automatic logic [31:0] pick_delta(int cap);
    logic [31:0] m;
    case ($urandom_range(19))
      0: return 32'h8000_0000;
      1: return 32'd0;
      2, 3, 4: return $urandom();
      default: m = $urandom_range(cap, 1);
    endcase
    return $urandom_range(1) ? m : 32'd0 - m;
  endfunction

  // clear, maybe setpos, arm, usually ramp, then a burst of ticks; sometimes random commands instead
  task automatic build_move(ref int n);
    int         cap;
    logic [3:0] pm;
    logic [3:0] nm;
    cap = (regs.master_count == 0) ? 4 :
          (regs.master_count > 40) ? 40 : int'(regs.master_count);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(4, 1))
        push_cmd(make_cmd(3'($urandom_range(7)), 2'($urandom()), $urandom(), $urandom(),
                          4'($urandom()), 4'($urandom())), n);
    end else begin
      push_cmd(make_cmd(OP_CLEAR, 2'($urandom()), $urandom(), $urandom(),
                        4'($urandom()), 4'($urandom())), n);
      if ($urandom_range(3) == 0)
        push_cmd(make_cmd(OP_SETPOS, 2'($urandom()), $urandom(), $urandom(),
                          4'($urandom()), 4'($urandom())), n);
      repeat ($urandom_range(4, 1))
        push_cmd(make_cmd(OP_ARM, 2'($urandom()), pick_delta(cap), $urandom(),
                          4'($urandom()), 4'($urandom())), n);
      if ($urandom_range(4) != 0)
        push_cmd(make_cmd(OP_RAMP, 2'($urandom()), $urandom(), $urandom(),
                          4'($urandom()), 4'($urandom())), n);
      repeat (cap + $urandom_range(8)) begin
        if ($urandom_range(19) == 0) begin
          pm = $urandom();
          nm = $urandom();
        end else begin
          pm = '1;
          nm = '1;
        end
        push_cmd(make_cmd(OP_TICK, 2'($urandom()), $urandom(), $urandom(), pm, nm), n);
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MASTER_COUNT: regs.master_count      = val[30:0];
      REG_TRACK_STEPS:  regs.track_steps       = val[0];
      REG_RAMP_ENABLE:  regs.ramp_enable       = val[0];
      REG_RAMP_START:   regs.start_period      = val[15:0];
      REG_RAMP_CRUISE:  regs.cruise_period     = val[15:0];
      REG_RAMP_STEP:    regs.period_step       = val[15:0];
      REG_RAMP_DECEL:   regs.decel_point       = val[15:0];
      REG_RAMP_TOTAL:   regs.ramp_total_ticks  = val[30:0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_setting(input int k);
    logic [31:0] v [8];
    case (k)
      0: v = '{8, 1, 1, 200, 20, 15, 6, 12};
      1: v = '{32'h7FFF_FFFF, 0, 1, 65535, 1, 65535, 65535, 32'h7FFF_FFFF};
      2: v = '{0, 1, 0, 1, 1, 1, 0, 0};
      3: begin
        v[0] = $urandom_range(16, 1);
        v[1] = $urandom_range(1);
        v[2] = 1;
        v[3] = $urandom_range(65535, 2);
        v[4] = $urandom_range(v[3] - 1, 1);
        v[5] = $urandom_range(400, 1);
        v[6] = $urandom_range(20, 1);
        v[7] = $urandom_range(64, 4);
      end
      4: v = '{12, 1, 1, 300, 40, 9, 0, 50};
      5: v = '{3, 1, 1, 40, 10, 2, 5, 3};
      6: v = '{20, 0, 1, 30, 30, 4, 10, 40};
      default: v = '{1, 1, 1, 100, 10, 30, 3, 8};
    endcase
    write_reg(REG_MASTER_COUNT, v[0]);
    write_reg(REG_TRACK_STEPS,  v[1]);
    write_reg(REG_RAMP_ENABLE,  v[2]);
    write_reg(REG_RAMP_START,   v[3]);
    write_reg(REG_RAMP_CRUISE,  v[4]);
    write_reg(REG_RAMP_STEP,    v[5]);
    write_reg(REG_RAMP_DECEL,   v[6]);
    write_reg(REG_RAMP_TOTAL,   v[7]);
  endtask

  task automatic wait_drained;
    @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_ch.valid || step_results_q.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int n;
    int idle_tx [3];
    int idle_rx [3];
    idle_tx = '{26, 83, 0};
    idle_rx = '{83, 26, 0};
    n = 0;

    cmd_ch.valid          = 1'b0;
    cmd_ch.op             = OP_TICK;
    cmd_ch.joint          = '0;
    cmd_ch.joint_delta    = '0;
    cmd_ch.position_value = '0;
    cmd_ch.pos_ok_mask    = '0;
    cmd_ch.neg_ok_mask    = '0;
    res_ch.ready          = 1'b0;
    on_wire               = '0;

    regs.master_count      = 31'd1;
    regs.track_steps       = 1'b0;
    regs.ramp_enable       = 1'b0;
    regs.start_period      = 16'd65535;
    regs.cruise_period     = 16'd1;
    regs.period_step       = 16'd1;
    regs.decel_point       = 16'd0;
    regs.ramp_total_ticks  = 31'd0;
    for (int i = 0; i < JOINTS; i++) begin
      joint_acc[i]  = '0;
      joint_mag[i]  = '0;
      joint_dir[i]  = 1'b0;
      joint_left[i] = '0;
      joint_pos[i]  = '0;
    end
    live_axes   = '0;
    prof_phase  = PH_NONE;
    ramp_period = '0;
    ramp_left   = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: every op, saturating delta, position wrap, ramp phases, abort, retire
    tx_idle = idle_tx[0];
    rx_idle = idle_rx[0];
    apply_setting(7);
    push_cmd(make_cmd(OP_TICK, 0, 0, 0, '1, '1), n);
    push_cmd(make_cmd(3'd5, 1, '1, '1, '1, '1), n);
    push_cmd(make_cmd(3'd7, 2, '1, '1, '1, '1), n);
    push_cmd(make_cmd(OP_ARM, 0, 0, 0, '1, '1), n);
    push_cmd(make_cmd(OP_SETPOS, 3, 0, 32'h7FFF_FFFF, 0, 0), n);
    push_cmd(make_cmd(OP_SETPOS, 2, 0, 32'h8000_0000, 0, 0), n);
    push_cmd(make_cmd(OP_ARM, 0, 32'd3, 0, 0, 0), n);
    push_cmd(make_cmd(OP_ARM, 1, 32'hFFFF_FFFE, 0, 0, 0), n);
    push_cmd(make_cmd(OP_ARM, 2, 32'h8000_0000, 0, 0, 0), n);
    push_cmd(make_cmd(OP_ARM, 3, 32'h7FFF_FFFF, 0, 0, 0), n);
    push_cmd(make_cmd(OP_RAMP, 0, 0, 0, 0, 0), n);
    for (int i = 0; i < 6; i++)
      push_cmd(make_cmd(OP_TICK, 2'(i), 0, 0, '1, '1), n);
    push_cmd(make_cmd(OP_TICK, 2, 0, 0, 4'b0111, '1), n);
    push_cmd(make_cmd(OP_TICK, 3, 0, 0, '1, '1), n);
    push_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0), n);
    push_cmd(make_cmd(OP_ARM, 1, 32'd1, 0, 0, 0), n);
    push_cmd(make_cmd(OP_TICK, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1), n);
    push_cmd(make_cmd(3'd6, 0, 0, 0, 0, 0), n);
    push_cmd(make_cmd(OP_TICK, 0, 0, 0, '1, '0), n);

    for (int ph = 0; ph < 3; ph++) begin
      for (int s = 0; s < 7; s++) begin
        wait_drained();
        tx_idle = idle_tx[ph];
        rx_idle = idle_rx[ph];
        apply_setting(s);
        n = 0;
        while (n < BATCH_ITEMS)
          build_move(n);
        if (ph == 2 && s == 0) begin
          @(posedge clk);
          hold_req <= 1'b1;
          @(posedge clk);
          hold_req <= 1'b0;
        end
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (step_results_q.size() != 0)
      report("results still outstanding", step_results_q.size(), 0);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/mdda_pkg.sv
rtl/mdda_if.sv
rtl/mdda_cfg.sv
rtl/mdda_ramp.sv
rtl/mdda_axes.sv
rtl/multi_axis_dda_step_generator_top.sv
tb/sv/tb_top.sv
